FILE: rtl/fbg_pkg.sv
// Package for the four corner bilinear gradient unit.
// Holds register indexes, field widths and the divider cell beat type.
package fbg_pkg;
	localparam int MaxDim = 4096;
	localparam int DimW = 13;
	localparam int CoordW = 12;
	localparam int ColorW = 24;
	localparam int ChanW = 8;
	localparam int NumChan = 3;
	localparam int SideW = 20;
	localparam int NumW = 32;
	localparam int AreaW = 25;
	localparam int NumCells = ChanW;

	typedef enum logic [2:0] {
		REG_WIDTH = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_TOP_LEFT = 3'd2,
		REG_TOP_RIGHT = 3'd3,
		REG_BOTTOM_LEFT = 3'd4,
		REG_BOTTOM_RIGHT = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [NumChan-1:0][NumW-1:0] rem;
		logic [NumW-1:0] dv;
		logic [NumChan-1:0][ChanW-1:0] quo;
	} div_beat_t;
endpackage

FILE: rtl/fbg_div_cell.sv
// One restoring division cell: settles one quotient bit for all channels.
// Depends on fbg_pkg.
module fbg_div_cell import fbg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vld_i,
	input  div_beat_t beat_i,
	output logic      vld_o,
	output div_beat_t beat_o
);
	logic      vld_q;
	div_beat_t beat_q;
	div_beat_t beat_n;

	always_comb begin
		beat_n.dv = beat_i.dv >> 1;
		for (int c = 0; c < NumChan; c++) begin
			if (beat_i.rem[c] >= beat_i.dv) begin
				beat_n.rem[c] = beat_i.rem[c] - beat_i.dv;
				beat_n.quo[c] = {beat_i.quo[c][ChanW-2:0], 1'b1};
			end else begin
				beat_n.rem[c] = beat_i.rem[c];
				beat_n.quo[c] = {beat_i.quo[c][ChanW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beat_q <= beat_n;
		end
	end

	assign vld_o = vld_q;
	assign beat_o = beat_q;
endmodule

FILE: rtl/four_corner_bilinear_gradient_unit.sv
// Top level of the four corner bilinear gradient unit.
// Depends on fbg_pkg and fbg_div_cell.
//
// Usage:
//   Write the image size and the four corner colors on the cfg port
//   (cfg_we, cfg_index, cfg_data) while no beat is in flight.
//   Sizes of 0 count as 1, sizes above 4096 as 4096; coordinates past the
//   edge clamp to the last column or row. Row 0 is the bottom row.
//   Input beat: pixel_x, pixel_y under in_valid / in_stall.
//   Output beat: red, green, blue under out_valid / out_stall.
//   Throughput: one pixel per cycle while out_stall is low.
//   Pipeline: the clamp and pixel area product stage, two multiply stages for
//   the blend numerators, and eight divider cells, one quotient bit each; the
//   last cell is the output register.
//   When out_stall is high with a beat waiting, the whole pipe holds and
//   in_stall rises in the same cycle.
//   Reset clears all valid bits and loads a 1024 by 768 image with black
//   corners.
module four_corner_bilinear_gradient_unit import fbg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [ColorW-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CoordW-1:0] pixel_x,
	input  logic [CoordW-1:0] pixel_y,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ChanW-1:0]  red,
	output logic [ChanW-1:0]  green,
	output logic [ChanW-1:0]  blue
);
	logic [DimW-1:0] width_q, height_q;
	logic [ColorW-1:0] tl_q, tr_q, bl_q, br_q;
	logic [DimW-1:0] wc, hc, xc, yc;
	logic en;

	logic vld_s1, vld_s2, vld_s3;
	logic [DimW-1:0] x_s1, y_s1, wx_s1, hy_s1;
	logic [AreaW-1:0] area_s1;
	logic [AreaW-1:0] area_s2, area_s3;
	logic [DimW-1:0] x_s2, wx_s2;
	logic [NumChan-1:0][SideW-1:0] left_s2, right_s2;
	logic [NumChan-1:0][NumW-1:0] num_s3;

	logic [NumCells:0] cvld;
	div_beat_t cbeat [NumCells+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DimW'(1024);
			height_q <= DimW'(768);
			tl_q <= '0;
			tr_q <= '0;
			bl_q <= '0;
			br_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH: width_q <= cfg_data[DimW-1:0];
				REG_HEIGHT: height_q <= cfg_data[DimW-1:0];
				REG_TOP_LEFT: tl_q <= cfg_data;
				REG_TOP_RIGHT: tr_q <= cfg_data;
				REG_BOTTOM_LEFT: bl_q <= cfg_data;
				REG_BOTTOM_RIGHT: br_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (width_q == '0) wc = DimW'(1);
		else if (width_q > DimW'(MaxDim)) wc = DimW'(MaxDim);
		else wc = width_q;
		priority if (height_q == '0) hc = DimW'(1);
		else if (height_q > DimW'(MaxDim)) hc = DimW'(MaxDim);
		else hc = height_q;
		xc = ({1'b0, pixel_x} > wc - DimW'(1)) ? wc - DimW'(1) : {1'b0, pixel_x};
		yc = ({1'b0, pixel_y} > hc - DimW'(1)) ? hc - DimW'(1) : {1'b0, pixel_y};
	end

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= xc;
			y_s1 <= yc;
			wx_s1 <= wc - xc;
			hy_s1 <= hc - yc;
			area_s1 <= AreaW'(wc) * AreaW'(hc);
			area_s2 <= area_s1;
			x_s2 <= x_s1;
			wx_s2 <= wx_s1;
			for (int c = 0; c < NumChan; c++) begin
				left_s2[c] <= SideW'(hy_s1) * SideW'(bl_q[c*ChanW +: ChanW])
					+ SideW'(y_s1) * SideW'(tl_q[c*ChanW +: ChanW]);
				right_s2[c] <= SideW'(hy_s1) * SideW'(br_q[c*ChanW +: ChanW])
					+ SideW'(y_s1) * SideW'(tr_q[c*ChanW +: ChanW]);
				num_s3[c] <= NumW'(wx_s2) * NumW'(left_s2[c])
					+ NumW'(x_s2) * NumW'(right_s2[c]);
			end
			area_s3 <= area_s2;
		end
	end

	assign cvld[0] = vld_s3;
	always_comb begin
		cbeat[0].rem = num_s3;
		cbeat[0].dv = NumW'({area_s3, 7'b0});
		cbeat[0].quo = '0;
	end

	for (genvar k = 0; k < NumCells; k++) begin : g_cell
		fbg_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (cvld[k]),
			.beat_i (cbeat[k]),
			.vld_o  (cvld[k+1]),
			.beat_o (cbeat[k+1])
		);
	end

	assign out_valid = cvld[NumCells];
	assign red = cbeat[NumCells].quo[2];
	assign green = cbeat[NumCells].quo[1];
	assign blue = cbeat[NumCells].quo[0];
endmodule

FILE: tb/sv/tb_top.sv
// Testbench for four_corner_bilinear_gradient_unit: table of directed beats, then random phases.
// Predicts pixel colors the table does not give from its own copy of the registers; depends on fbg_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
	import fbg_pkg::*;

	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int DRAIN_CYCLES = 14;
	localparam int IDLE_LIMIT = 5000;

	typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_EXP} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [2:0] idx;
		logic [23:0] data;
		logic [11:0] x;
		logic [11:0] y;
		logic [23:0] rgb;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [ColorW-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [CoordW-1:0] pixel_x;
	logic [CoordW-1:0] pixel_y;
	logic out_valid;
	logic out_stall;
	logic [ChanW-1:0] red;
	logic [ChanW-1:0] green;
	logic [ChanW-1:0] blue;

	logic [12:0] img_w;
	logic [12:0] img_h;
	logic [23:0] tl_color;
	logic [23:0] tr_color;
	logic [23:0] bl_color;
	logic [23:0] br_color;

	rgb_t pending_colors[$];
	int errors = 0;
	int idle_cycles = 0;
	bit tx_quiet = 0;
	bit rx_quiet = 0;
	int stall_left = 0;

	four_corner_bilinear_gradient_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.red(red), .green(green), .blue(blue)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic rgb_t blend_pixel(logic [11:0] px, logic [11:0] py);
		longint unsigned w, h, x, y, tl, tr, bl, br, left, right, v;
		logic [23:0] res;
		w = (img_w == 0) ? 64'd1 : (img_w > MaxDim) ? 64'(MaxDim) : 64'(img_w);
		h = (img_h == 0) ? 64'd1 : (img_h > MaxDim) ? 64'(MaxDim) : 64'(img_h);
		x = (64'(px) > w - 1) ? w - 1 : 64'(px);
		y = (64'(py) > h - 1) ? h - 1 : 64'(py);
		for (int sh = 0; sh < 24; sh += 8) begin
			tl = 64'((tl_color >> sh) & 24'hFF);
			tr = 64'((tr_color >> sh) & 24'hFF);
			bl = 64'((bl_color >> sh) & 24'hFF);
			br = 64'((br_color >> sh) & 24'hFF);
			left = (h - y) * bl + y * tl;
			right = (h - y) * br + y * tr;
			v = ((w - x) * left + x * right) / (w * h);
			if (v > 255)
				v = 255;
			res[sh +: 8] = v[7:0];
		end
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDTH: img_w = data[12:0];
			REG_HEIGHT: img_h = data[12:0];
			REG_TOP_LEFT: tl_color = data;
			REG_TOP_RIGHT: tr_color = data;
			REG_BOTTOM_LEFT: bl_color = data;
			REG_BOTTOM_RIGHT: br_color = data;
			default: ;
		endcase
	endtask

	task automatic send_pixel(logic [11:0] x, logic [11:0] y, bit typed, rgb_t typed_rgb);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		do @(posedge clk); while (in_stall);
		pending_colors.push_back(typed ? typed_rgb : blend_pixel(x, y));
	endtask

	function automatic logic [12:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'd4096;
			3: return 13'h1FFF;
			4: return 13'($urandom_range(4097, 8191));
			5: return 13'($urandom_range(1, 4096));
			default: return 13'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic logic [23:0] pick_color();
		case ($urandom_range(0, 5))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return 24'($urandom_range(0, 24'hFFFFFF));
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_colors.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: r=%0h g=%0h b=%0h", red, green, blue);
			end else begin
				rgb_t want;
				want = pending_colors.pop_front();
				if (want.r !== red || want.g !== green || want.b !== blue) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %0h %0h %0h, got %0h %0h %0h",
							want.r, want.g, want.b, red, green, blue);
				end
			end
		end
		if (rx_quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 75) begin
				out_stall <= 1'b0;
			end else if (r < 95) begin
				stall_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				stall_left = $urandom_range(5, 25);
				out_stall <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	stim_row_t directed[$] = '{
		'{ROW_PIX_EXP, 3'd0, 24'h0, 12'd0, 12'd0, 24'h000000},
		'{ROW_PIX_EXP, 3'd0, 24'h0, 12'hFFF, 12'hFFF, 24'h000000},
		'{ROW_CFG, REG_TOP_LEFT, 24'hFFFFFF, 12'd0, 12'd0, 24'h0},
		'{ROW_CFG, REG_TOP_RIGHT, 24'hFFFFFF, 12'd0, 12'd0, 24'h0},
		'{ROW_CFG, REG_BOTTOM_LEFT, 24'hFFFFFF, 12'd0, 12'd0, 24'h0},
		'{ROW_CFG, REG_BOTTOM_RIGHT, 24'hFFFFFF, 12'd0, 12'd0, 24'h0},
		'{ROW_PIX_EXP, 3'd0, 24'h0, 12'd0, 12'd0, 24'hFFFFFF},
		'{ROW_PIX_EXP, 3'd0, 24'h0, 12'hFFF, 12'hFFF, 24'hFFFFFF},
		'{ROW_PIX, 3'd0, 24'h0, 12'd512, 12'd300, 24'h0},
		'{ROW_CFG, REG_BOTTOM_LEFT, 24'hFF0000, 12'd0, 12'd0, 24'h0},
		'{ROW_CFG, REG_BOTTOM_RIGHT, 24'h00FF00, 12'd0, 12'd0, 24'h0},
		'{ROW_CFG, REG_TOP_LEFT, 24'h0000FF, 12'd0, 12'd0, 24'h0},
		'{ROW_CFG, REG_TOP_RIGHT, 24'h808080, 12'd0, 12'd0, 24'h0},
		'{ROW_CFG, REG_WIDTH, 24'h0, 12'd0, 12'd0, 24'h0},
		'{ROW_CFG, REG_HEIGHT, 24'h0, 12'd0, 12'd0, 24'h0},
		'{ROW_PIX_EXP, 3'd0, 24'h0, 12'd0, 12'd0, 24'hFF0000},
		'{ROW_PIX_EXP, 3'd0, 24'h0, 12'hFFF, 12'hFFF, 24'hFF0000},
		'{ROW_CFG, REG_WIDTH, 24'h1FFF, 12'd0, 12'd0, 24'h0},
		'{ROW_CFG, REG_HEIGHT, 24'd5000, 12'd0, 12'd0, 24'h0},
		'{ROW_PIX_EXP, 3'd0, 24'h0, 12'd0, 12'd0, 24'hFF0000},
		'{ROW_PIX, 3'd0, 24'h0, 12'hFFF, 12'hFFF, 24'h0},
		'{ROW_PIX, 3'd0, 24'h0, 12'hFFF, 12'd0, 24'h0},
		'{ROW_CFG, REG_SPARE_LO, 24'hFFFFFF, 12'd0, 12'd0, 24'h0},
		'{ROW_CFG, REG_SPARE_HI, 24'h123456, 12'd0, 12'd0, 24'h0},
		'{ROW_PIX_EXP, 3'd0, 24'h0, 12'd0, 12'd0, 24'hFF0000},
		'{ROW_CFG, REG_WIDTH, 24'hFFE005, 12'd0, 12'd0, 24'h0},
		'{ROW_CFG, REG_HEIGHT, 24'd3, 12'd0, 12'd0, 24'h0},
		'{ROW_PIX, 3'd0, 24'h0, 12'd4, 12'd2, 24'h0},
		'{ROW_PIX, 3'd0, 24'h0, 12'd9, 12'd5, 24'h0},
		'{ROW_PIX, 3'd0, 24'h0, 12'd2, 12'd1, 24'h0}
	};

	initial begin
		logic [11:0] x;
		logic [11:0] y;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		out_stall = 1'b0;
		img_w = 13'd1024;
		img_h = 13'd768;
		tl_color = '0;
		tr_color = '0;
		bl_color = '0;
		br_color = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG)
				write_reg(directed[i].idx, directed[i].data);
			else
				send_pixel(directed[i].x, directed[i].y,
					directed[i].kind == ROW_PIX_EXP, directed[i].rgb);
		end

		for (int phase = 0; phase < 7; phase++) begin
			tx_quiet = (phase % 3 == 0);
			rx_quiet = (phase % 3 == 0);
			write_reg(REG_WIDTH, 24'((phase == 1) ? 13'd4096 : pick_dim()));
			write_reg(REG_HEIGHT, 24'((phase == 1) ? 13'd4096 : pick_dim()));
			write_reg(REG_TOP_LEFT, pick_color());
			write_reg(REG_TOP_RIGHT, pick_color());
			write_reg(REG_BOTTOM_LEFT, pick_color());
			write_reg(REG_BOTTOM_RIGHT, pick_color());
			tx_quiet = (phase % 3 == 0);
			for (int n = 0; n < 150; n++) begin
				if (phase == 2 && n == 75)
					drain();
				if ($urandom_range(0, 3) == 0) begin
					x = 12'($urandom_range(0, 4095));
					y = 12'($urandom_range(0, 4095));
				end else begin
					x = 12'($urandom_range(0, (img_w > 1) ? img_w - 1 : 0));
					y = 12'($urandom_range(0, (img_h > 1) ? img_h - 1 : 0));
				end
				send_pixel(x, y, 1'b0, '0);
			end
		end

		drain();
		repeat (30) @(posedge clk);
		if (errors == 0 && pending_colors.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/fbg_pkg.sv
rtl/fbg_div_cell.sv
rtl/four_corner_bilinear_gradient_unit.sv
tb/sv/tb_top.sv
